// ===== sv/exponential_settle_profile_top_macros.svh =====
// ----------------------------------------------------------------------------
// exponential settle profile assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_SETTLE_PROFILE_TOP_MACROS_SVH
`define EXPONENTIAL_SETTLE_PROFILE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ESP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define ESP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define ESP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define ESP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== sv/esp_pkg.sv =====
// ----------------------------------------------------------------------------
// esp_pkg
// shared constants, types and saturating helpers of the settle profile
// ----------------------------------------------------------------------------
package esp_pkg;

    localparam int VW      = 32;
    localparam int FB      = 16;
    localparam int TW      = 31;
    localparam int N_TERMS = 20;

    localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] ONE_Q     = 64'sd1 <<< FB;
    localparam logic signed [63:0] TWO_Q     = 64'sd2 <<< FB;
    localparam logic signed [63:0] X_HI      = 64'sd64 <<< FB;
    localparam logic signed [63:0] X_LO      = -(64'sd45 <<< FB);
    localparam logic signed [63:0] LOG2E_Q60 = 64'sh1715_4765_2B82_FE17;
    // ln 2 in q64, halved so it fits a signed operand (it is even)
    localparam logic signed [63:0] LN2_HALF  = 64'sh58B9_0BFB_E8E7_BCD6;
    localparam logic signed [63:0] SER_ONE   = 64'sd1 <<< 62;
    localparam logic signed [63:0] EXP_BIAS  = 64'sd128 <<< 32;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_START_VALUE = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_RATE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_ACCEL = 3'd2;
    localparam logic [IDX_W-1:0] REG_MATCH_TIME  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DECAY_TIME  = 3'd4;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic signed [63:0] inv;
        logic signed [31:0] t0;
        logic               busy;
    } coef_t;

    // everything an item carries along the pipeline
    typedef struct packed {
        logic signed [63:0] dt;
        logic signed [63:0] x;
        logic signed [63:0] omx;
        logic signed [63:0] xm2;
        logic signed [63:0] vsum;
        logic signed [63:0] bi;
        logic signed [7:0]  pw;
        logic signed [63:0] w;
        logic signed [63:0] sum;
        logic signed [63:0] e;
        logic signed [63:0] rr;
        logic signed [63:0] aa;
        logic signed [63:0] ei;
        logic signed [63:0] value;
    } side_t;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [VW-1:0] sat_out(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[VW-1:0];
    endfunction

endpackage

// ===== sv/exponential_settle_profile_top.sv =====
// ----------------------------------------------------------------------------
// exponential_settle_profile_top
// streaming evaluator of a profile that settles exponentially to a constant
// ----------------------------------------------------------------------------
// Each word on s_axis carries a sample time t (signed q16.16); each word on
// m_axis carries the profile value and its first and second time derivative
// at t, all signed q16.16 and saturated. The block takes one word per clock
// while the output buffer has room and no coefficient update is running, and
// delivers results in order through a chain of three-stage multipliers, forty
// of which sit in the twenty-term power series for e^-x. A two-word output
// buffer keeps the pipeline running while one finished word waits; the whole
// pipeline stalls only when that buffer is full. After a configuration write
// the coefficient sequencer derives 1/tau with a bit-per-cycle reciprocal,
// then c, b and a; cfg_ready and s_axis_tready stay low during that time.
// ----------------------------------------------------------------------------
`include "exponential_settle_profile_top_macros.svh"

module exponential_settle_profile_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [esp_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // [31:0] sample_time
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [95:0]               m_axis_tdata    // [31:0] value_out,
                                                      // [63:32] rate_out,
                                                      // [95:64] accel_out
);
    import esp_pkg::*;

    coef_t              coef;
    logic               en, acc, push, pop;
    logic [1:0]         cnt_reg, cnt_next;
    logic               wp_reg, rp_reg;
    logic [95:0]        buf_reg [2];
    logic [95:0]        out_word;

    // stage signals: s<n> registers between the multiplier groups
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    side_t              s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    side_t              s1_next, s2_next, s3_next, s4_next, s5_next;

    logic               vm1, vm2, vm3, vser, vm4, vm5;
    side_t              sm1, sm2, sm3, sser_in, sser, sm4, sm5;
    logic signed [63:0] x_p, cdt_p, bi_p, z_p, cx1_p, cx2_p, w_p;
    logic signed [63:0] ev_p, er_p, ei_p, acc_p;
    logic signed [63:0] xc, u;
    logic signed [8:0]  sh9;

    // the pipeline moves as a whole whenever the output buffer has room
    assign en            = cnt_reg != 2'd2;
    assign s_axis_tready = en && !coef.busy;
    assign acc           = s_axis_tvalid && s_axis_tready;

    esp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // time offset from the match point
    always_comb
    begin
        s1_next    = '0;
        s1_next.dt = ssub(64'($signed(s_axis_tdata)), 64'(coef.t0));
    end

    // x = dt/tau, c*dt and b/tau
    esp_mul u_m1x (.clk(clk), .rst_n(rst_n), .en(en), .vin(v1_reg), .a(s1_reg.dt),
                   .b(coef.inv), .sh(7'(FB)), .rnd(1'b1), .side_in(s1_reg),
                   .vout(vm1), .p(x_p), .side_out(sm1));
    esp_mul u_m1c (.clk(clk), .rst_n(rst_n), .en(en), .vin(v1_reg), .a(coef.c),
                   .b(s1_reg.dt), .sh(7'(FB)), .rnd(1'b1), .side_in(s1_reg),
                   .vout(), .p(cdt_p), .side_out());
    esp_mul u_m1b (.clk(clk), .rst_n(rst_n), .en(en), .vin(v1_reg), .a(coef.b),
                   .b(coef.inv), .sh(7'(FB)), .rnd(1'b1), .side_in(s1_reg),
                   .vout(), .p(bi_p), .side_out());

    always_comb
    begin
        s2_next      = sm1;
        s2_next.x    = x_p;
        s2_next.omx  = ssub(ONE_Q, x_p);
        s2_next.xm2  = ssub(x_p, TWO_Q);
        s2_next.vsum = sadd(coef.b, cdt_p);
        s2_next.bi   = bi_p;
        // the exponent only needs x inside the range where e^-x is still finite
        if (x_p > X_HI)
        begin
            xc = X_HI;
        end
        else if (x_p < X_LO)
        begin
            xc = X_LO;
        end
        else
        begin
            xc = x_p;
        end
        // the z multiplier takes the clamped exponent in the w slot
        // (w is otherwise free until the series)
        s2_next.w    = -(xc <<< (32 - FB));
    end

    // z = -x * log2(e) in q32, plus c*(1-x) and c*(x-2)
    esp_mul u_m2z (.clk(clk), .rst_n(rst_n), .en(en), .vin(v2_reg),
                   .a(s2_reg.w), .b(LOG2E_Q60),
                   .sh(7'd60), .rnd(1'b1), .side_in(s2_reg),
                   .vout(vm2), .p(z_p), .side_out(sm2));
    esp_mul u_m2a (.clk(clk), .rst_n(rst_n), .en(en), .vin(v2_reg), .a(coef.c),
                   .b(s2_reg.omx), .sh(7'(FB)), .rnd(1'b1), .side_in(s2_reg),
                   .vout(), .p(cx1_p), .side_out());
    esp_mul u_m2b (.clk(clk), .rst_n(rst_n), .en(en), .vin(v2_reg), .a(coef.c),
                   .b(s2_reg.xm2), .sh(7'(FB)), .rnd(1'b1), .side_in(s2_reg),
                   .vout(), .p(cx2_p), .side_out());

    // split z into integer power and 32-bit fraction
    always_comb
    begin
        u          = z_p + EXP_BIAS;
        s3_next    = sm2;
        s3_next.pw = $signed(u[39:32] - 8'd128);
        s3_next.w  = 64'(u[31:0]);
        s3_next.rr = ssub(cx1_p, sm2.bi);
        s3_next.aa = sadd(cx2_p, sm2.bi);
    end

    // series argument: fraction times ln 2, q62
    esp_mul u_m3 (.clk(clk), .rst_n(rst_n), .en(en), .vin(v3_reg), .a(s3_reg.w),
                  .b(LN2_HALF), .sh(7'd33), .rnd(1'b0), .side_in(s3_reg),
                  .vout(vm3), .p(w_p), .side_out(sm3));

    always_comb
    begin
        sser_in     = sm3;
        sser_in.w   = w_p;
        sser_in.sum = SER_ONE;
    end

    esp_series u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (vm3),
        .side_in  (sser_in),
        .vout     (vser),
        .side_out (sser)
    );

    // scale the series sum by the integer power into q16
    always_comb
    begin
        s4_next = sser;
        sh9     = 9'sd46 - {sser.pw[7], sser.pw};
        if (sh9 >= 9'sd64)
        begin
            s4_next.e = '0;
        end
        else if (sh9 < 9'sd0)
        begin
            s4_next.e = S64_MAX;
        end
        else if (sh9 == 9'sd0)
        begin
            s4_next.e = sser.sum;
        end
        else
        begin
            // unsigned shift: the rounded sum may reach the top bit
            s4_next.e = (sser.sum + (64'sd1 <<< (sh9[5:0] - 6'd1))) >> sh9[5:0];
        end
    end

    // products with e
    esp_mul u_m4v (.clk(clk), .rst_n(rst_n), .en(en), .vin(v4_reg), .a(s4_reg.vsum),
                   .b(s4_reg.e), .sh(7'(FB)), .rnd(1'b1), .side_in(s4_reg),
                   .vout(vm4), .p(ev_p), .side_out(sm4));
    esp_mul u_m4r (.clk(clk), .rst_n(rst_n), .en(en), .vin(v4_reg), .a(s4_reg.e),
                   .b(s4_reg.rr), .sh(7'(FB)), .rnd(1'b1), .side_in(s4_reg),
                   .vout(), .p(er_p), .side_out());
    esp_mul u_m4i (.clk(clk), .rst_n(rst_n), .en(en), .vin(v4_reg), .a(s4_reg.e),
                   .b(coef.inv), .sh(7'(FB)), .rnd(1'b1), .side_in(s4_reg),
                   .vout(), .p(ei_p), .side_out());

    always_comb
    begin
        s5_next       = sm4;
        s5_next.value = sadd(coef.a, ev_p);
        s5_next.rr    = er_p;
        s5_next.ei    = ei_p;
    end

    // second derivative
    esp_mul u_m5 (.clk(clk), .rst_n(rst_n), .en(en), .vin(v5_reg), .a(s5_reg.ei),
                  .b(s5_reg.aa), .sh(7'(FB)), .rnd(1'b1), .side_in(s5_reg),
                  .vout(vm5), .p(acc_p), .side_out(sm5));

    assign out_word = {sat_out(acc_p), sat_out(sm5.rr), sat_out(sm5.value)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= acc;
            v2_reg <= vm1;
            v3_reg <= vm2;
            v4_reg <= vser;
            v5_reg <= vm4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    // two-word output buffer
    assign push = en && vm5;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        priority if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= out_word;
        end
    end

    assign m_axis_tvalid = cnt_reg != 2'd0;
    assign m_axis_tdata  = buf_reg[rp_reg];

    `ESP_ASSERT_IMP(a_no_item_while_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !coef.busy, "item taken during coefficient update")
    `ESP_ASSERT_IMP(a_buf_count, clk, rst_n, 1'b1, cnt_reg != 2'd3, "output buffer count out of range")
    `ESP_ASSERT_NXT(a_full_holds, clk, rst_n, cnt_reg == 2'd2 && !m_axis_tready, cnt_reg == 2'd2, "full buffer changed without a read")

endmodule

// ===== sv/esp_mul.sv =====
// ----------------------------------------------------------------------------
// esp_mul
// three-stage signed multiply, rounding or truncating shift, 64-bit saturate
// ----------------------------------------------------------------------------
module esp_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic [6:0]         sh,
    input  logic               rnd,
    input  esp_pkg::side_t     side_in,
    output logic               vout,
    output logic signed [63:0] p,
    output esp_pkg::side_t     side_out
);
    import esp_pkg::*;

    logic [63:0]  ma, mb;
    logic         v1_reg, v2_reg, v3_reg;
    logic         neg1_reg, neg2_reg;
    logic [6:0]   sh1_reg, sh2_reg;
    logic         rnd1_reg;
    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] prod_next, prod2_reg;
    logic [127:0] shv;
    logic [63:0]  lim, mag;
    logic signed [63:0] p_next, p_reg;
    side_t        s1_reg, s2_reg, s3_reg;

    assign ma = a[63] ? 64'(-a) : 64'(a);
    assign mb = b[63] ? 64'(-b) : 64'(b);

    always_comb
    begin
        prod_next = {64'd0, pp00_reg} + ({64'd0, pp01_reg} << 32)
                  + ({64'd0, pp10_reg} << 32) + ({64'd0, pp11_reg} << 64);
        if (rnd1_reg)
        begin
            prod_next = prod_next + (128'd1 << (sh1_reg - 7'd1));
        end
    end

    always_comb
    begin
        shv = prod2_reg >> sh2_reg;
        lim = neg2_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        mag = (shv[127:64] != 64'd0 || shv[63:0] > lim) ? lim : shv[63:0];
        p_next = neg2_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= a[63] != b[63];
            sh1_reg   <= sh;
            rnd1_reg  <= rnd;
            pp00_reg  <= ma[31:0]  * mb[31:0];
            pp01_reg  <= ma[31:0]  * mb[63:32];
            pp10_reg  <= ma[63:32] * mb[31:0];
            pp11_reg  <= ma[63:32] * mb[63:32];
            s1_reg    <= side_in;
            neg2_reg  <= neg1_reg;
            sh2_reg   <= sh1_reg;
            prod2_reg <= prod_next;
            s2_reg    <= s1_reg;
            p_reg     <= p_next;
            s3_reg    <= s2_reg;
        end
    end

    assign vout     = v3_reg;
    assign p        = p_reg;
    assign side_out = s3_reg;

endmodule

// ===== sv/esp_cfg.sv =====
// ----------------------------------------------------------------------------
// esp_cfg
// configuration registers and the sequencer that derives a, b, c and 1/tau
// ----------------------------------------------------------------------------
`include "exponential_settle_profile_top_macros.svh"

module esp_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [esp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [31:0]                  cfg_data,
    output esp_pkg::coef_t               coef
);
    import esp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CMUL = 3'd2;
    localparam logic [2:0] ST_BLO  = 3'd3;
    localparam logic [2:0] ST_BHI  = 3'd4;
    localparam logic [2:0] ST_AFIN = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic signed [31:0] sv_reg, sr_reg, sa_reg, mt_reg;
    logic [TW-1:0]      dk_reg;
    logic [TW-1:0]      d31;
    logic [33:0]        num;
    logic [5:0]         bit_reg, bit_next;
    logic [31:0]        rem_reg, rem_next, rem_sh;
    logic [33:0]        quo_reg, quo_next;
    logic signed [63:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, inv_reg, inv_next;
    logic               negm_reg, negm_next;
    logic [15:0]        mhi_reg, mhi_next;
    logic [62:0]        plo_reg, plo_next;
    logic [31:0]        mag2;
    logic [62:0]        pr;
    logic signed [63:0] s64, m64, mm;
    logic [79:0]        full;
    logic               wr;

    assign wr  = cfg_valid && cfg_ready;
    assign d31 = (dk_reg == '0) ? TW'(1) : dk_reg;
    assign num = 34'h1_0000_0000 + 34'(d31[TW-1:1]);
    assign rem_sh = {rem_reg[30:0], num[bit_reg]};

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        inv_next   = inv_reg;
        negm_next  = negm_reg;
        mhi_next   = mhi_reg;
        plo_next   = plo_reg;
        mag2 = sa_reg[31] ? 32'(-sa_reg) : 32'(sa_reg);
        pr   = {31'd0, mag2} * {32'd0, d31};
        pr   = pr + 63'd32768;
        s64  = sa_reg[31] ? -$signed(64'(pr[62:16])) : $signed(64'(pr[62:16]));
        m64  = c_reg - 64'(sr_reg);
        mm   = m64[63] ? -m64 : m64;
        full = 80'(plo_reg) + (80'({31'd0, mhi_reg} * {16'd0, d31}) << 32) + 80'd32768;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (wr)
                begin
                    state_next = ST_DIV;
                    bit_next   = 6'd33;
                    rem_next   = '0;
                    quo_next   = '0;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, restoring division
                if (rem_sh >= {1'b0, d31})
                begin
                    rem_next = rem_sh - {1'b0, d31};
                    quo_next = {quo_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[32:0], 1'b0};
                end
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL:
            begin
                inv_next   = 64'(quo_reg);
                c_next     = -64'(sr_reg) - s64;
                state_next = ST_BLO;
            end
            ST_BLO:
            begin
                negm_next  = m64[63];
                plo_next   = {31'd0, mm[31:0]} * {32'd0, d31};
                mhi_next   = mm[47:32];
                state_next = ST_BHI;
            end
            ST_BHI:
            begin
                b_next     = negm_reg ? -$signed(full[79:16]) : $signed(full[79:16]);
                state_next = ST_AFIN;
            end
            ST_AFIN:
            begin
                a_next     = ssub(64'(sv_reg), b_reg);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sv_reg    <= '0;
            sr_reg    <= '0;
            sa_reg    <= '0;
            mt_reg    <= '0;
            dk_reg    <= TW'(65536);
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            inv_reg   <= 64'sd65536;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            inv_reg   <= inv_next;
            if (wr)
            begin
                unique case (cfg_index)
                    REG_START_VALUE: sv_reg <= cfg_data;
                    REG_START_RATE:  sr_reg <= cfg_data;
                    REG_START_ACCEL: sa_reg <= cfg_data;
                    REG_MATCH_TIME:  mt_reg <= cfg_data;
                    REG_DECAY_TIME:  dk_reg <= cfg_data[TW-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        negm_reg <= negm_next;
        mhi_reg  <= mhi_next;
        plo_reg  <= plo_next;
    end

    assign cfg_ready  = state_reg == ST_IDLE;
    assign coef.a     = a_reg;
    assign coef.b     = b_reg;
    assign coef.c     = c_reg;
    assign coef.inv   = inv_reg;
    assign coef.t0    = mt_reg;
    assign coef.busy  = state_reg != ST_IDLE;

    `ESP_ASSERT_NXT(a_write_starts_calc, clk, rst_n, wr, coef.busy, "write did not start coefficient update")
    `ESP_ASSERT_IMP(a_inv_nonzero, clk, rst_n, !coef.busy, inv_reg > 64'sd0, "reciprocal of tau is not positive")
    `ESP_ASSERT_NXT(a_div_to_cmul, clk, rst_n, state_reg == ST_DIV && bit_reg == 6'd0, state_reg == ST_CMUL, "division did not end on last bit")

endmodule

// ===== sv/esp_series.sv =====
// ----------------------------------------------------------------------------
// esp_series
// power series of 2^frac, one term per pair of multipliers
// ----------------------------------------------------------------------------
module esp_series (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vin,
    input  esp_pkg::side_t side_in,
    output logic           vout,
    output esp_pkg::side_t side_out
);
    import esp_pkg::*;

    logic               v_a [N_TERMS];
    logic               v_b [N_TERMS];
    logic signed [63:0] prod_a [N_TERMS];
    logic signed [63:0] term_b [N_TERMS];
    side_t              side_a [N_TERMS];
    side_t              side_b [N_TERMS];
    side_t              side_u [N_TERMS];

    for (genvar k = 0; k < N_TERMS; k++)
    begin : g_term
        localparam int DIVR = k + 1;
        localparam int LG   = $clog2(DIVR);
        // exact floor division by the term index via a rounded-up reciprocal
        localparam logic [127:0] MBIG =
            ((128'd1 << (62 + LG)) + 128'(DIVR) - 128'd1) / 128'(DIVR);
        localparam logic signed [63:0] MUL_C = MBIG[63:0];
        localparam logic [6:0]         SH_C  = 7'(62 + LG);

        logic               vi;
        logic signed [63:0] ti;
        side_t              si;

        if (k == 0)
        begin : g_first
            assign vi = vin;
            assign ti = SER_ONE;
            assign si = side_in;
        end
        else
        begin : g_next
            assign vi = v_b[k-1];
            assign ti = term_b[k-1];
            assign si = side_u[k-1];
        end

        esp_mul u_pw (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vin      (vi),
            .a        (ti),
            .b        (si.w),
            .sh       (7'd62),
            .rnd      (1'b0),
            .side_in  (si),
            .vout     (v_a[k]),
            .p        (prod_a[k]),
            .side_out (side_a[k])
        );

        esp_mul u_dv (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vin      (v_a[k]),
            .a        (prod_a[k]),
            .b        (MUL_C),
            .sh       (SH_C),
            .rnd      (1'b0),
            .side_in  (side_a[k]),
            .vout     (v_b[k]),
            .p        (term_b[k]),
            .side_out (side_b[k])
        );

        always_comb
        begin
            side_u[k]     = side_b[k];
            side_u[k].sum = side_b[k].sum + term_b[k];
        end
    end

    assign vout     = v_b[N_TERMS-1];
    assign side_out = side_u[N_TERMS-1];

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// streaming test of the exponential settle profile evaluator
// ----------------------------------------------------------------------------
// Each register set is programmed while the block is idle. Sample times go in
// on s_axis, and a bit-exact software predictor forms the expected value, rate
// and acceleration for each accepted word. Results on m_axis are compared in
// order. Both sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
    import esp_pkg::*;

    localparam logic [63:0] LOG2E_FX = 64'h1715_4765_2B82_FE17;
    localparam logic [63:0] LN2_FX   = 64'hB172_17F7_D1CF_79AC;
    localparam logic signed [63:0] BIG_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] BIG_NEG = 64'sh8000_0000_0000_0000;
    localparam int CYCLE_LIMIT = 900000;

    // expected-result store and bit-exact predictor of the profile
    class profile_scoreboard;
        logic [31:0] f_val, f_rate, f_acc, t_match;
        logic [30:0] tau_reg;
        logic [95:0] pending[$];
        int errors;

        function new();
            f_val = 0; f_rate = 0; f_acc = 0; t_match = 0;
            tau_reg = 31'd65536; errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_START_VALUE: f_val   = data;
                REG_START_RATE:  f_rate  = data;
                REG_START_ACCEL: f_acc   = data;
                REG_MATCH_TIME:  t_match = data;
                REG_DECAY_TIME:  tau_reg = data[30:0];
                default: ;
            endcase
        endfunction

        // round(a*b / 2^s), ties away from zero, saturated to 64 bits
        function logic signed [63:0] fx_mul(logic signed [63:0] a,
                                            logic signed [63:0] b, int s);
            logic [63:0] ua, ub, lim;
            logic [127:0] p;
            logic neg;
            neg = a[63] ^ b[63];
            ua = a[63] ? 64'd0 - a : a;
            ub = b[63] ? 64'd0 - b : b;
            p = {64'd0, ua} * {64'd0, ub};
            p = (p + (128'd1 << (s - 1))) >> s;
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (p[127:64] != 0 || p[63:0] > lim) p[63:0] = lim;
            return neg ? 64'd0 - p[63:0] : p[63:0];
        endfunction

        function logic signed [63:0] fx_add(logic signed [63:0] a, logic signed [63:0] b);
            logic [64:0] r;
            r = {a[63], a} + {b[63], b};
            if (r[64] != r[63]) return r[64] ? BIG_NEG : BIG_POS;
            return r[63:0];
        endfunction

        function logic signed [63:0] fx_sub(logic signed [63:0] a, logic signed [63:0] b);
            logic [64:0] r;
            r = {a[63], a} - {b[63], b};
            if (r[64] != r[63]) return r[64] ? BIG_NEG : BIG_POS;
            return r[63:0];
        endfunction

        // e^-x in q16.16 via 2^(-x log2 e), integer and fractional power
        function logic signed [63:0] decay_factor(logic signed [63:0] x);
            logic signed [63:0] xc, z;
            logic [63:0] u, q, w, term, sum, r;
            logic [127:0] prod;
            int pw, sh;
            xc = x;
            if (xc > (64'sd64 <<< 16)) xc = 64'sd64 <<< 16;
            if (xc < -(64'sd45 <<< 16)) xc = -(64'sd45 <<< 16);
            z = fx_mul((-xc) <<< 16, LOG2E_FX, 60);
            u = z + (64'd128 << 32);
            pw = int'(u >> 32) - 128;
            q = {32'd0, u[31:0]};
            prod = ({64'd0, q} * {64'd0, LN2_FX}) >> 34;
            w = prod[63:0];
            term = 64'd1 << 62;
            sum = term;
            for (int i = 1; i <= 20; i++)
            begin
                prod = ({64'd0, term} * {64'd0, w}) >> 62;
                term = prod[63:0] / i;
                sum = sum + term;
            end
            sh = 62 - pw - 16;
            if (sh >= 64) return 0;
            if (sh < 0) return BIG_POS;
            if (sh == 0) return sum;
            r = (sum + (64'd1 << (sh - 1))) >> sh;
            return r;
        endfunction

        function logic [31:0] clip32(logic signed [63:0] v);
            if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
            if (v < -64'sh8000_0000) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function logic [95:0] profile_at(logic [31:0] t);
            logic signed [63:0] f0, f1, f2, t0, tau, c, b, a, inv, dt, x, e, ei;
            logic signed [63:0] val, rt, ac;
            logic [127:0] quo;
            f0 = $signed(f_val); f1 = $signed(f_rate); f2 = $signed(f_acc);
            t0 = $signed(t_match);
            tau = {33'd0, tau_reg};
            if (tau == 0) tau = 1;   // zero decay time acts as one step
            c = fx_sub(fx_sub(0, f1), fx_mul(f2, tau, 16));
            b = fx_mul(fx_sub(c, f1), tau, 16);
            a = fx_sub(f0, b);
            quo = ((128'd1 << 32) + (tau >>> 1)) / {64'd0, tau};
            inv = (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? BIG_POS : quo[63:0];
            dt = fx_sub($signed(t), t0);
            x = fx_mul(dt, inv, 16);
            e = decay_factor(x);
            val = fx_add(a, fx_mul(fx_add(b, fx_mul(c, dt, 16)), e, 16));
            rt = fx_mul(e, fx_sub(fx_mul(c, fx_sub(64'sd1 <<< 16, x), 16),
                                  fx_mul(b, inv, 16)), 16);
            ei = fx_mul(e, inv, 16);
            ac = fx_mul(ei, fx_add(fx_mul(c, fx_sub(x, 64'sd2 <<< 16), 16),
                                   fx_mul(inv, b, 16)), 16);
            return {clip32(ac), clip32(rt), clip32(val)};
        endfunction

        function void note_sample(logic [31:0] t);
            pending.push_back(profile_at(t));
        endfunction

        function void check_result(logic [95:0] got);
            logic [95:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 3; k++)
                if (want[32*k +: 32] != got[32*k +: 32])
                begin
                    $display("%0t: field %0d mismatch, expected %h actual %h",
                             $time, k, want[32*k +: 32], got[32*k +: 32]);
                    errors++;
                end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [31:0]        cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [95:0]        m_axis_tdata;

    profile_scoreboard sb = new();
    bit quiet;       // set for the last phase: no idling on either side
    int cycles;

    exponential_settle_profile_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // every accepted result word goes to the checker
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // receiver stalls in random bursts
    initial
    begin
        int n;
        bit v;
        m_axis_tready = 1'b0;
        forever
        begin
            n = $urandom_range(1, 18);
            v = ($urandom_range(0, 2) != 0);
            repeat (n)
            begin
                @(negedge clk);
                m_axis_tready <= quiet | v;
            end
        end
    end

    // register write, held until the sequencer takes it
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for the pipeline to drain before touching the registers
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic send_sample(logic [31:0] t);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(t);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;   // about +-8
            2: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
            default: return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_tau();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
        endcase
    endfunction

    // sample times mostly within a few decay times of the match time
    function automatic logic [31:0] rand_time();
        logic [31:0] span;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return sb.t_match + ($urandom & 32'h003F_FFFF) - 32'h0010_0000;
            default:
            begin
                span = (sb.tau_reg > 31'h00FF_FFFF) ? 32'h0FFF_FFFF
                                                     : {sb.tau_reg, 1'b0} * 16;
                if (span == 0) span = 32'd64;
                return sb.t_match + ($urandom % span) - span / 4;
            end
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed_t [12];
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero trajectory, unit decay time
        directed_t = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0040_0000, 32'h0041_0000, 32'hFFD3_0000, 32'hFFD2_0000,
                       32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000};
        foreach (directed_t[i]) send_sample(directed_t[i]);

        // extreme register sets, including zero decay and ignored indexes
        drain();
        write_reg(REG_START_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_START_RATE,  32'h7FFF_FFFF);
        write_reg(REG_START_ACCEL, 32'h7FFF_FFFF);
        write_reg(REG_MATCH_TIME,  32'h7FFF_FFFF);
        write_reg(REG_DECAY_TIME,  32'h7FFF_FFFF);
        write_reg(3'd5, 32'hFFFF_FFFF);
        foreach (directed_t[i]) if (i < 5) send_sample(directed_t[i]);
        drain();
        write_reg(REG_START_VALUE, 32'h8000_0000);
        write_reg(REG_START_RATE,  32'h8000_0000);
        write_reg(REG_START_ACCEL, 32'h8000_0000);
        write_reg(REG_MATCH_TIME,  32'h8000_0000);
        write_reg(REG_DECAY_TIME,  32'h8000_0000);   // upper bit dropped: zero
        write_reg(3'd6, 32'h1234_5678);
        write_reg(3'd7, 32'h0);
        foreach (directed_t[i]) if (i < 5) send_sample(directed_t[i]);
        drain();
        write_reg(REG_START_VALUE, 32'h0001_0000);
        write_reg(REG_START_RATE,  32'hFFFE_0000);
        write_reg(REG_START_ACCEL, 32'h0000_8000);
        write_reg(REG_MATCH_TIME,  32'h0);
        write_reg(REG_DECAY_TIME,  32'h1);
        foreach (directed_t[i]) if (i < 4) send_sample(directed_t[i]);

        // random phases; the last one runs with no idling
        for (int ph = 0; ph < 20; ph++)
        begin
            drain();
            if (ph == 19) quiet = 1'b1;
            write_reg(REG_START_VALUE, rand_coef());
            write_reg(REG_START_RATE,  rand_coef());
            write_reg(REG_START_ACCEL, rand_coef());
            write_reg(REG_MATCH_TIME,  rand_coef());
            write_reg(REG_DECAY_TIME,  rand_tau());
            if ($urandom_range(0, 3) == 0)
                write_reg(IDX_W'($urandom_range(5, 7)), $urandom);
            repeat (92) send_sample(rand_time());
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/esp_pkg.sv
sv/esp_mul.sv
sv/esp_cfg.sv
sv/esp_series.sv
sv/exponential_settle_profile_top.sv
bench/tb_top.sv
